// ----- rtl/bsmm_pkg.sv -----
package bsmm_pkg;

  localparam int REQ_W    = 2;
  localparam int IDX_W    = 5;
  localparam int VALUE_W  = 16;
  localparam int PROD_W   = 37;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_DIM  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] MATRIX_DIM_RESET  = 6'd32;
  localparam logic [CFG_W-1:0] SLICE_COUNT_RESET = 6'd1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    CMD_WR_A,
    CMD_WR_B,
    CMD_RD,
    CMD_RD_BAD
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product_value;
    logic                     status;
  } res_t;

endpackage

// ----- rtl/batched_square_matrix_multiply.sv -----
// Channel   Ports                                   Moves
// input     in_push / in_full, in_* fields          one request item
// result    out_pop / out_empty, out_* fields       one result item
// config    cfg_wr_en, cfg_index, cfg_data          one register write
//
// A write item is written into its memory as the execution stage takes it. A read item
// starts, then reads one element pair per cycle from the A and B memories, then waits
// while the multiply and accumulate pipeline drains.
// A read outside the dimension or slice count gives a range result without a memory read.
// Reset clears only control state; the element memories hold nothing defined.
// The two-entry command queue keeps accepting items while a read runs, and a
// read starts only when the result queue has room.
module batched_square_matrix_multiply #(
  parameter int MAX_DIM    = 32,
  parameter int MAX_SLICES = 32,
  parameter int ELEM_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [bsmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsmm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [bsmm_pkg::REQ_W-1:0]           in_req_type,
  input  logic [bsmm_pkg::IDX_W-1:0]           in_row_index,
  input  logic [bsmm_pkg::IDX_W-1:0]           in_col_index,
  input  logic [bsmm_pkg::IDX_W-1:0]           in_slice_index,
  input  logic signed [bsmm_pkg::VALUE_W-1:0]  in_element_value,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [bsmm_pkg::PROD_W-1:0]   out_product_value,
  output logic                                 out_status
);

  import bsmm_pkg::*;

  localparam int DEPTH = MAX_SLICES * MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int KW    = $bits(cmd_kind_t);
  localparam int CW    = KW + 2 * AW + DW + ELEM_BITS;
  localparam int RW    = $bits(res_t);

  logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_kind_t            f_kind;
  logic [AW-1:0]        f_addr_a, f_addr_b;
  logic [DW-1:0]        f_dim;
  logic [ELEM_BITS-1:0] f_data;
  logic [CW-1:0]        cmd_in, cmd_out;
  logic                 res_push, res_full;
  res_t                 res_in, res_out;
  logic [RW-1:0]        res_q;

  bsmm_front #(
    .MAX_DIM    (MAX_DIM),
    .MAX_SLICES (MAX_SLICES),
    .ELEM_BITS  (ELEM_BITS),
    .AW         (AW),
    .DW         (DW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_slice_index   (in_slice_index),
    .in_element_value (in_element_value),
    .cmd_full         (cmd_full),
    .cmd_push         (cmd_push),
    .cmd_kind         (f_kind),
    .cmd_addr_a       (f_addr_a),
    .cmd_addr_b       (f_addr_b),
    .cmd_dim          (f_dim),
    .cmd_data         (f_data)
  );

  assign cmd_in = {f_kind, f_addr_a, f_addr_b, f_dim, f_data};

  bsmm_fifo #(
    .WIDTH (CW),
    .DEPTH (2)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  bsmm_back #(
    .MAX_DIM    (MAX_DIM),
    .MAX_SLICES (MAX_SLICES),
    .ELEM_BITS  (ELEM_BITS),
    .AW         (AW),
    .DW         (DW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .cmd_kind   (cmd_kind_t'(cmd_out[CW-1 -: KW])),
    .cmd_addr_a (cmd_out[CW-KW-1 -: AW]),
    .cmd_addr_b (cmd_out[CW-KW-AW-1 -: AW]),
    .cmd_dim    (cmd_out[ELEM_BITS+DW-1 -: DW]),
    .cmd_data   (cmd_out[ELEM_BITS-1:0]),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_in)
  );

  bsmm_fifo #(
    .WIDTH (RW),
    .DEPTH (2)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_q),
    .empty     (out_empty)
  );

  assign res_out           = res_t'(res_q);
  assign out_product_value = res_out.product_value;
  assign out_status        = res_out.status;

endmodule

// ----- rtl/bsmm_ram.sv -----
module bsmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/bsmm_fifo.sv -----
module bsmm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = store_r[rptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/bsmm_front.sv -----
module bsmm_front #(
  parameter int MAX_DIM    = 32,
  parameter int MAX_SLICES = 32,
  parameter int ELEM_BITS  = 16,
  parameter int AW         = 15,
  parameter int DW         = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bsmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsmm_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [bsmm_pkg::REQ_W-1:0]       in_req_type,
  input  logic [bsmm_pkg::IDX_W-1:0]       in_row_index,
  input  logic [bsmm_pkg::IDX_W-1:0]       in_col_index,
  input  logic [bsmm_pkg::IDX_W-1:0]       in_slice_index,
  input  logic signed [bsmm_pkg::VALUE_W-1:0] in_element_value,
  input  logic                             cmd_full,
  output logic                             cmd_push,
  output bsmm_pkg::cmd_kind_t              cmd_kind,
  output logic [AW-1:0]                    cmd_addr_a,
  output logic [AW-1:0]                    cmd_addr_b,
  output logic [DW-1:0]                    cmd_dim,
  output logic [ELEM_BITS-1:0]             cmd_data
);

  import bsmm_pkg::*;

  localparam int CMPW = CFG_W + 1;

  logic [CFG_W-1:0] matrix_dim_r, matrix_dim_nxt;
  logic [CFG_W-1:0] slice_count_r, slice_count_nxt;
  logic [CMPW-1:0]  dim_eff;
  logic [CMPW-1:0]  slices_eff;
  logic             in_range;
  logic             keep;

  always_comb begin
    matrix_dim_nxt  = matrix_dim_r;
    slice_count_nxt = slice_count_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_MATRIX_DIM:  matrix_dim_nxt  = cfg_data;
        REG_SLICE_COUNT: slice_count_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_dim_r  <= MATRIX_DIM_RESET;
      slice_count_r <= SLICE_COUNT_RESET;
    end else begin
      matrix_dim_r  <= matrix_dim_nxt;
      slice_count_r <= slice_count_nxt;
    end
  end

  always_comb begin
    dim_eff = {1'b0, matrix_dim_r};
    if (dim_eff > CMPW'(MAX_DIM)) begin
      dim_eff = CMPW'(MAX_DIM);
    end
    slices_eff = {1'b0, slice_count_r};
    if (slices_eff > CMPW'(MAX_SLICES)) begin
      slices_eff = CMPW'(MAX_SLICES);
    end
  end

  assign in_range = (CMPW'(in_row_index) < dim_eff) && (CMPW'(in_col_index) < dim_eff) &&
                    (CMPW'(in_slice_index) < slices_eff);

  always_comb begin
    keep     = 1'b0;
    cmd_kind = CMD_RD_BAD;
    case (in_req_type)
      REQ_WRITE_A: begin
        keep     = in_range;
        cmd_kind = CMD_WR_A;
      end
      REQ_WRITE_B: begin
        keep     = in_range;
        cmd_kind = CMD_WR_B;
      end
      REQ_READ: begin
        keep     = 1'b1;
        cmd_kind = in_range ? CMD_RD : CMD_RD_BAD;
      end
      default: ;
    endcase
  end

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full && keep;

  assign cmd_addr_a = AW'((32'(in_slice_index) * MAX_DIM + 32'(in_row_index)) * MAX_DIM +
                          ((in_req_type == REQ_READ) ? 32'd0 : 32'(in_col_index)));
  assign cmd_addr_b = AW'(32'(in_slice_index) * MAX_DIM * MAX_DIM + 32'(in_col_index));
  assign cmd_dim    = DW'(dim_eff);
  assign cmd_data   = ELEM_BITS'($unsigned(in_element_value));

endmodule

// ----- rtl/bsmm_back.sv -----
module bsmm_back #(
  parameter int MAX_DIM    = 32,
  parameter int MAX_SLICES = 32,
  parameter int ELEM_BITS  = 16,
  parameter int AW         = 15,
  parameter int DW         = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  bsmm_pkg::cmd_kind_t  cmd_kind,
  input  logic [AW-1:0]        cmd_addr_a,
  input  logic [AW-1:0]        cmd_addr_b,
  input  logic [DW-1:0]        cmd_dim,
  input  logic [ELEM_BITS-1:0] cmd_data,
  input  logic                 res_full,
  output logic                 res_push,
  output bsmm_pkg::res_t       res_data
);

  import bsmm_pkg::*;

  localparam int DEPTH = MAX_SLICES * MAX_DIM * MAX_DIM;
  localparam int MW    = 2 * ELEM_BITS;

  back_state_t state_r, state_nxt;

  logic [AW-1:0]           a_addr_r, a_addr_nxt;
  logic [AW-1:0]           b_addr_r, b_addr_nxt;
  logic [DW-1:0]           cnt_r, cnt_nxt;
  logic                    v1_r, v2_r;
  logic signed [MW-1:0]    prod_r;
  logic signed [PROD_W-1:0] prod_ext;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic                    issue;
  logic                    a_wr_en, b_wr_en;
  logic [ELEM_BITS-1:0]    a_rdata, b_rdata;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && cmd_kind == CMD_RD && !res_full) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        if (cnt_r == DW'(1)) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!v1_r && !v2_r) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_data   = '{product_value: acc_r, status: STATUS_OK};
    a_wr_en    = 1'b0;
    b_wr_en    = 1'b0;
    issue      = 1'b0;
    a_addr_nxt = a_addr_r;
    b_addr_nxt = b_addr_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = v2_r ? acc_r + prod_ext : acc_r;
    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_kind)
            CMD_WR_A: begin
              cmd_pop = 1'b1;
              a_wr_en = 1'b1;
            end
            CMD_WR_B: begin
              cmd_pop = 1'b1;
              b_wr_en = 1'b1;
            end
            CMD_RD: begin
              if (!res_full) begin
                cmd_pop    = 1'b1;
                a_addr_nxt = cmd_addr_a;
                b_addr_nxt = cmd_addr_b;
                cnt_nxt    = cmd_dim;
                acc_nxt    = '0;
              end
            end
            CMD_RD_BAD: begin
              if (!res_full) begin
                cmd_pop  = 1'b1;
                res_push = 1'b1;
                res_data = '{product_value: '0, status: STATUS_RANGE};
              end
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        issue      = 1'b1;
        a_addr_nxt = a_addr_r + 1'b1;
        b_addr_nxt = b_addr_r + AW'(MAX_DIM);
        cnt_nxt    = cnt_r - 1'b1;
      end
      BK_FLUSH: begin
        if (!v1_r && !v2_r) begin
          res_push = 1'b1;
        end
      end
      default: ;
    endcase
  end

  generate
    if (MW >= PROD_W) begin : g_trunc
      assign prod_ext = prod_r[PROD_W-1:0];
    end else begin : g_sext
      assign prod_ext = {{(PROD_W - MW){prod_r[MW-1]}}, prod_r};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= a_addr_nxt;
    b_addr_r <= b_addr_nxt;
    cnt_r    <= cnt_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= $signed(a_rdata) * $signed(b_rdata);
  end

  bsmm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (cmd_addr_a),
    .wr_data (cmd_data),
    .rd_en   (issue),
    .rd_addr (a_addr_r),
    .rd_data (a_rdata)
  );

  bsmm_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (cmd_addr_a),
    .wr_data (cmd_data),
    .rd_en   (issue),
    .rd_addr (b_addr_r),
    .rd_data (b_rdata)
  );

endmodule

// ----- verif/tb_batched_square_matrix_multiply.sv -----
`timescale 1ns / 100ps

module tb_batched_square_matrix_multiply;
  import bsmm_pkg::*;

  localparam int MAX_DIM       = 32;
  localparam int MAX_SLICES    = 32;
  localparam int STORE_DEPTH   = MAX_SLICES * MAX_DIM * MAX_DIM;
  localparam int HALF_PERIOD   = 6;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 2000000;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7fff;

  typedef struct {
    logic [REQ_W-1:0]          req;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic [IDX_W-1:0]          slc;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [REQ_W-1:0]           in_req_type = '0;
  logic [IDX_W-1:0]           in_row_index = '0;
  logic [IDX_W-1:0]           in_col_index = '0;
  logic [IDX_W-1:0]           in_slice_index = '0;
  logic signed [VALUE_W-1:0]  in_element_value = '0;
  logic                       out_pop = 1'b0;
  logic                       out_empty;
  logic signed [PROD_W-1:0]   out_product_value;
  logic                       out_status;

  request_t pending_requests[$];
  res_t     expected_products[$];
  res_t     oldest_product;

  logic signed [VALUE_W-1:0] a_mem [STORE_DEPTH];
  logic signed [VALUE_W-1:0] b_mem [STORE_DEPTH];
  bit                        a_written [STORE_DEPTH];
  bit                        b_written [STORE_DEPTH];
  logic [CFG_W-1:0]          matrix_dim_reg = MATRIX_DIM_RESET;
  logic [CFG_W-1:0]          slice_count_reg = SLICE_COUNT_RESET;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_request = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int range_results = 0;
  int settings_count = 0;

  batched_square_matrix_multiply u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_req_type       (in_req_type),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .in_slice_index    (in_slice_index),
    .in_element_value  (in_element_value),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_product_value (out_product_value),
    .out_status        (out_status)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  function automatic int eff_dim();
    return (matrix_dim_reg > MAX_DIM) ? MAX_DIM : int'(matrix_dim_reg);
  endfunction

  function automatic int eff_slices();
    return (slice_count_reg > MAX_SLICES) ? MAX_SLICES : int'(slice_count_reg);
  endfunction

  function automatic int store_addr(int s, int r, int c);
    return (s * MAX_DIM + r) * MAX_DIM + c;
  endfunction

  function automatic bit in_range(int r, int c, int s);
    return r < eff_dim() && c < eff_dim() && s < eff_slices();
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2: return '0;
      3: return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // A read inside the range is preceded by writes of every operand entry
  // that has not been loaded yet, so no unloaded entry is ever used.
  function automatic int queue_item(logic [REQ_W-1:0] req, int r, int c, int s,
                                    logic signed [VALUE_W-1:0] v);
    request_t item;
    int counted;
    int k;
    counted = 0;
    if (req == REQ_READ) begin
      if (in_range(r, c, s)) begin
        for (k = 0; k < eff_dim(); k++) begin
          if (!a_written[store_addr(s, r, k)])
            counted += queue_item(REQ_WRITE_A, r, k, s, rand_value());
          if (!b_written[store_addr(s, k, c)])
            counted += queue_item(REQ_WRITE_B, k, c, s, rand_value());
        end
      end
      counted++;
    end else if (req == REQ_WRITE_A || req == REQ_WRITE_B) begin
      if (in_range(r, c, s)) begin
        if (req == REQ_WRITE_A) a_written[store_addr(s, r, c)] = 1'b1;
        else b_written[store_addr(s, r, c)] = 1'b1;
        counted++;
      end
    end
    item.req   = req;
    item.row   = r[IDX_W-1:0];
    item.col   = c[IDX_W-1:0];
    item.slc   = s[IDX_W-1:0];
    item.value = v;
    pending_requests.push_back(item);
    return counted;
  endfunction

  function automatic void load_row_column(int r, int c, int s,
                                          logic signed [VALUE_W-1:0] a_val,
                                          logic signed [VALUE_W-1:0] b_val);
    int k;
    for (k = 0; k < eff_dim(); k++) begin
      void'(queue_item(REQ_WRITE_A, r, k, s, a_val));
      void'(queue_item(REQ_WRITE_B, k, c, s, b_val));
    end
    void'(queue_item(REQ_READ, r, c, s, rand_value()));
  endfunction

  function automatic bit pick_out_of_range(output int r, output int c, output int s);
    int d;
    int es;
    d  = eff_dim();
    es = eff_slices();
    r  = $urandom_range(MAX_DIM - 1);
    c  = $urandom_range(MAX_DIM - 1);
    s  = $urandom_range(MAX_SLICES - 1);
    if (d < MAX_DIM && (es == MAX_SLICES || $urandom_range(1) == 1)) begin
      if ($urandom_range(1) == 1) r = $urandom_range(MAX_DIM - 1, d);
      else c = $urandom_range(MAX_DIM - 1, d);
      return 1'b1;
    end
    if (es < MAX_SLICES) begin
      s = $urandom_range(MAX_SLICES - 1, es);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_slice(int es);
    if ($urandom_range(3) != 0) return ($urandom_range(1) == 1) ? es - 1 : 0;
    return $urandom_range(es - 1);
  endfunction

  function automatic void generate_requests(int n);
    int issued;
    int roll;
    int r;
    int c;
    int s;
    int d;
    int es;
    logic [REQ_W-1:0] kind;
    issued = 0;
    d  = eff_dim();
    es = eff_slices();
    while (issued < n) begin
      roll = $urandom_range(99);
      kind = ($urandom_range(1) == 1) ? REQ_WRITE_B : REQ_WRITE_A;
      if (roll < 5) begin
        void'(queue_item(REQ_UNUSED, $urandom_range(31), $urandom_range(31),
                         $urandom_range(31), rand_value()));
      end else if (roll < 12) begin
        if (pick_out_of_range(r, c, s)) void'(queue_item(kind, r, c, s, rand_value()));
      end else if (roll < 20 || d == 0 || es == 0) begin
        if (pick_out_of_range(r, c, s))
          issued += queue_item(REQ_READ, r, c, s, rand_value());
      end else if (roll < 60) begin
        issued += queue_item(kind, $urandom_range(d - 1), $urandom_range(d - 1),
                             pick_slice(es), rand_value());
      end else begin
        issued += queue_item(REQ_READ, $urandom_range(d - 1), $urandom_range(d - 1),
                             pick_slice(es), rand_value());
      end
    end
  endfunction

  function automatic void apply_request(request_t item);
    res_t   result;
    longint acc;
    int     k;
    int     r;
    int     c;
    int     s;
    r = item.row;
    c = item.col;
    s = item.slc;
    if (item.req == REQ_WRITE_A) begin
      if (in_range(r, c, s)) a_mem[store_addr(s, r, c)] = item.value;
    end else if (item.req == REQ_WRITE_B) begin
      if (in_range(r, c, s)) b_mem[store_addr(s, r, c)] = item.value;
    end else if (item.req == REQ_READ) begin
      if (!in_range(r, c, s)) begin
        result.product_value = '0;
        result.status        = STATUS_RANGE;
      end else begin
        acc = 0;
        for (k = 0; k < eff_dim(); k++)
          acc += longint'(a_mem[store_addr(s, r, k)]) * longint'(b_mem[store_addr(s, k, c)]);
        result.product_value = acc[PROD_W-1:0];
        result.status        = STATUS_OK;
      end
      expected_products.push_back(result);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      apply_request(pending_requests[0]);
      void'(pending_requests.pop_front());
      items_accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
      in_push          <= 1'b1;
      in_req_type      <= pending_requests[0].req;
      in_row_index     <= pending_requests[0].row;
      in_col_index     <= pending_requests[0].col;
      in_slice_index   <= pending_requests[0].slc;
      in_element_value <= pending_requests[0].value;
    end else begin
      in_push <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_request != hold_taken) begin
      hold_taken <= hold_request;
      hold_left  <= HOLD_CYCLES;
      out_pop    <= 1'b0;
    end else begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      out_pop <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_products.size() == 0) begin
        $error("unexpected result item: product_value %0d status %0d",
               out_product_value, out_status);
        fail_count++;
      end else begin
        oldest_product = expected_products.pop_front();
        results_checked++;
        if (oldest_product.status == STATUS_RANGE) range_results++;
        if (out_product_value !== oldest_product.product_value) begin
          $error("product_value mismatch: expected %0d, actual %0d",
                 oldest_product.product_value, out_product_value);
          fail_count++;
        end
        if (out_status !== oldest_product.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 oldest_product.status, out_status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[batched_square_matrix_multiply] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_products.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_MATRIX_DIM) matrix_dim_reg = data;
    else slice_count_reg = data;
  endtask

  // Writes still in flight produce no result, so the block gets extra
  // cycles to finish them before the registers change.
  task automatic apply_setting(logic [CFG_W-1:0] dim, logic [CFG_W-1:0] slices);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_register(REG_MATRIX_DIM, dim);
    write_register(REG_SLICE_COUNT, slices);
    settings_count++;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] dim, logic [CFG_W-1:0] slices, int n,
                           int tx_pct, int rx_pct, bit hold);
    apply_setting(dim, slices);
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (hold) hold_request++;
    generate_requests(n);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    void'(queue_item(REQ_READ, 0, 0, 1, '0));
    void'(queue_item(REQ_WRITE_A, 0, 0, 3, 16'sd5));
    void'(queue_item(REQ_UNUSED, 31, 31, 31, '1));
    void'(queue_item(REQ_READ, 31, 31, 31, '0));

    apply_setting(6'd2, 6'd32);
    load_row_column(0, 0, 31, VALUE_MIN, VALUE_MIN);
    load_row_column(1, 1, 0, VALUE_MAX, VALUE_MIN);
    void'(queue_item(REQ_WRITE_A, 2, 0, 0, 16'sd7));
    void'(queue_item(REQ_READ, 0, 2, 0, '0));
    void'(queue_item(REQ_READ, 2, 0, 0, '0));
    void'(queue_item(REQ_READ, 0, 1, 0, '0));

    apply_setting(6'd0, 6'd32);
    void'(queue_item(REQ_READ, 0, 0, 31, '0));
    void'(queue_item(REQ_WRITE_B, 0, 0, 31, '0));

    apply_setting(6'd1, 6'd0);
    void'(queue_item(REQ_READ, 0, 0, 0, '0));

    run_phase(6'd4, 6'd2, 260, 0, 0, 1'b0);
    run_phase(6'd3, 6'd32, 260, 60, 0, 1'b0);
    run_phase(6'd1, 6'd1, 170, 0, 60, 1'b0);
    run_phase(6'd63, 6'd63, 170, 18, 18, 1'b0);
    load_row_column(0, 0, 0, VALUE_MIN, VALUE_MIN);
    load_row_column(31, 31, 31, VALUE_MIN, VALUE_MAX);
    run_phase(6'd5, 6'd7, 300, 30, 30, 1'b1);
    run_phase(6'd0, 6'd3, 40, 18, 18, 1'b0);
    run_phase(6'd6, 6'd0, 40, 0, 0, 1'b0);
    run_phase(6'd2, 6'd16, 210, 18, 18, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Accepted %0d request items over %0d register settings; checked %0d results,",
             items_accepted, settings_count, results_checked);
    $display("%0d of them range errors, with idle, stall and long hold-off phases.",
             range_results);
    if (fail_count == 0) begin
      $display("[batched_square_matrix_multiply] OK");
    end else begin
      $display("[batched_square_matrix_multiply] ERROR");
    end
    $finish;
  end

endmodule
